@@ design/decimal_text_to_float_defines.svh @@
// Assertion macros shared by the decimal text to float design files.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef DECIMAL_TEXT_TO_FLOAT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FLOAT_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define DTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define DTF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/dtf_pkg.sv @@
// Shared types, codes and constants of the decimal text to float block.
// No dependencies.
`default_nettype none
package dtf_pkg;

  // parse phases of the front end
  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_INT, PH_FRAC, PH_ESIGN, PH_EDIG
  } phase_e;

  // commands from front to back
  typedef enum logic [1:0] {
    CMD_DIGIT, CMD_NODIGIT, CMD_RANGE, CMD_FINISH
  } cmd_e;

  // float unit operations
  typedef enum logic [1:0] {
    FOP_MUL, FOP_ADD, FOP_DIV
  } fop_e;

  // float unit sequencer
  typedef enum logic [2:0] {
    FP_IDLE, FP_MULN, FP_NORM, FP_DIVP, FP_DIV, FP_ROUND
  } fpst_e;

  // back end sequencer
  typedef enum logic [3:0] {
    BK_IDLE, BK_MUL10, BK_MUL10_W, BK_ADD, BK_ADD_W,
    BK_SCALE, BK_SCALE_W, BK_SQ, BK_SQ_W, BK_EMIT
  } bkst_e;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NODIGIT = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [31:0] F_TEN  = 32'h4120_0000;
  localparam logic [31:0] F_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_QNAN = 32'h7FC0_0000;

  localparam logic [16:0] DIG_MAX  = 17'h1_FFFF;
  localparam logic [15:0] CHARS_MAX = 16'hFFFF;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;

  typedef struct packed {
    cmd_e        kind;
    logic [3:0]  digit;
    logic        first;
    logic        neg;
    logic        exneg;
    logic [7:0]  mag;
    logic [15:0] chars;
  } cmd_t;

  typedef struct packed {
    logic        start;
    fop_e        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] bits;
  } fpu_rsp_t;

  // a decimal digit as binary32
  function automatic logic [31:0] digit_to_float(input logic [3:0] d);
    logic [31:0] r;
    case (d)
      4'd1:    r = 32'h3F80_0000;
      4'd2:    r = 32'h4000_0000;
      4'd3:    r = 32'h4040_0000;
      4'd4:    r = 32'h4080_0000;
      4'd5:    r = 32'h40A0_0000;
      4'd6:    r = 32'h40C0_0000;
      4'd7:    r = 32'h40E0_0000;
      4'd8:    r = 32'h4100_0000;
      4'd9:    r = 32'h4110_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/dtf_front.sv @@
// Front end: parses characters, keeps counters and exponent, issues commands.
// Depends on dtf_pkg.
`default_nettype none
module dtf_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire  [7:0]       char_code_i,
  input  wire              start_of_string_i,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire              full_i,
  output logic             push_o,
  output dtf_pkg::cmd_t    cmd_o
);
  import dtf_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [16:0]            fdc_q, fdc_d, ed_q, ed_d;
  logic                   any_q, any_d, mneg_q, mneg_d, eneg_q, eneg_d;

  logic        accept, is_dig, is_sign, is_ws, is_e;
  logic        int_c, frac_c, expd_c, mant_end, fin, add_dig, inc;
  logic [3:0]  dval;
  logic [20:0] tmul;
  logic signed [18:0] exv, exmag;
  logic [31:0] cnt32;
  logic [15:0] chars;
  cmd_t        cmd;
  logic        push;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  // character classes
  always_comb begin
    is_dig  = char_code_i inside {[CH_0:CH_9]};
    is_sign = char_code_i inside {CH_PLUS, CH_MINUS};
    is_ws   = char_code_i inside {CH_SPACE, CH_TAB, CH_NL};
    is_e    = char_code_i inside {CH_LE, CH_UE};
    dval    = char_code_i[3:0];
  end

  // saturated character count for results
  always_comb begin
    cnt32 = 32'(cnt_q);
    chars = (cnt32 > 32'(CHARS_MAX)) ? CHARS_MAX : cnt32[15:0];
  end

  // parse step for one beat
  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; fdc_d = fdc_q; ed_d = ed_q;
    any_d = any_q; mneg_d = mneg_q; eneg_d = eneg_q;
    int_c = 1'b0; frac_c = 1'b0; expd_c = 1'b0;
    mant_end = 1'b0; fin = 1'b0; add_dig = 1'b0; inc = 1'b0;
    push = 1'b0;
    cmd = '0;
    tmul = 21'({ed_q, 3'b000}) + 21'({ed_q, 1'b0}) + 21'(dval);
    exv = '0;
    exmag = '0;

    if (start_of_string_i) begin
      phase_d = PH_LEAD; cnt_d = '0; fdc_d = '0; ed_d = '0;
      any_d = 1'b0; mneg_d = 1'b0; eneg_d = 1'b0;
      tmul = 21'(dval);
    end

    case (phase_d)
      PH_LEAD: begin
        if (is_ws) begin
          inc = 1'b1;
        end else if (is_sign) begin
          mneg_d  = (char_code_i == CH_MINUS);
          inc     = 1'b1;
          phase_d = PH_INT;
        end else begin
          phase_d = PH_INT;
          int_c   = 1'b1;
        end
      end
      PH_INT:  int_c  = 1'b1;
      PH_FRAC: frac_c = 1'b1;
      PH_ESIGN: begin
        if (is_sign) begin
          eneg_d  = (char_code_i == CH_MINUS);
          inc     = 1'b1;
          phase_d = PH_EDIG;
        end else begin
          expd_c = 1'b1;
        end
      end
      PH_EDIG: expd_c = 1'b1;
      default: ;
    endcase

    if (int_c) begin
      if (is_dig) begin
        add_dig = 1'b1; inc = 1'b1;
      end else if (char_code_i == CH_POINT) begin
        inc = 1'b1; phase_d = PH_FRAC;
      end else begin
        mant_end = 1'b1;
      end
    end

    if (frac_c) begin
      if (is_dig) begin
        add_dig = 1'b1; inc = 1'b1;
        if (fdc_d != DIG_MAX) fdc_d = fdc_d + 17'd1;
      end else begin
        mant_end = 1'b1;
      end
    end

    if (expd_c) begin
      if (is_dig) begin
        ed_d    = (tmul > 21'(DIG_MAX)) ? DIG_MAX : tmul[16:0];
        inc     = 1'b1;
        phase_d = PH_EDIG;
      end else begin
        fin = 1'b1;
      end
    end

    if (mant_end) begin
      if (!any_d) begin
        push = 1'b1; cmd.kind = CMD_NODIGIT; phase_d = PH_IDLE;
      end else if (is_e) begin
        inc = 1'b1; phase_d = PH_ESIGN;
      end else begin
        fin = 1'b1;
      end
    end

    if (add_dig) begin
      push      = 1'b1;
      cmd.kind  = CMD_DIGIT;
      cmd.digit = dval;
      cmd.first = !any_d;
      any_d     = 1'b1;
    end

    if (inc && (cnt_d != {COUNT_BITS{1'b1}})) cnt_d = cnt_d + 1'b1;

    // total exponent and range check
    if (fin) begin
      exv = (eneg_d ? -$signed({2'b00, ed_d}) : $signed({2'b00, ed_d}))
            - $signed({2'b00, fdc_d});
      exmag = exv[18] ? -exv : exv;
      push = 1'b1;
      phase_d = PH_IDLE;
      if (exv < -19'sd125 || exv > 19'sd128) begin
        cmd.kind = CMD_RANGE;
      end else begin
        cmd.kind  = CMD_FINISH;
        cmd.neg   = mneg_d;
        cmd.exneg = exv[18];
        cmd.mag   = exmag[7:0];
        cmd.chars = chars;
      end
    end

    // an idle item without start does nothing
    if (phase_q == PH_IDLE && !start_of_string_i) begin
      phase_d = PH_IDLE; push = 1'b0;
      cnt_d = cnt_q; fdc_d = fdc_q; ed_d = ed_q;
      any_d = any_q; mneg_d = mneg_q; eneg_d = eneg_q;
    end
  end

  assign push_o = accept && push;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      fdc_q   <= '0;
      ed_q    <= '0;
      any_q   <= 1'b0;
      mneg_q  <= 1'b0;
      eneg_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fdc_q   <= fdc_d;
      ed_q    <= ed_d;
      any_q   <= any_d;
      mneg_q  <= mneg_d;
      eneg_q  <= eneg_d;
    end
  end

endmodule
`default_nettype wire

@@ design/dtf_queue.sv @@
// Four entry command queue between front and back end.
// Depends on dtf_pkg.
`default_nettype none
module dtf_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  dtf_pkg::cmd_t  data_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           empty_o,
  output dtf_pkg::cmd_t  data_o
);
  import dtf_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ design/dtf_fpu.sv @@
// Multi-cycle binary32 unit: multiply, add of non-negative values, divide,
// round to nearest even with subnormal results. Depends on dtf_pkg.
`default_nettype none
`include "decimal_text_to_float_defines.svh"
module dtf_fpu (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  dtf_pkg::fpu_req_t  req_i,
  output dtf_pkg::fpu_rsp_t  rsp_o
);
  import dtf_pkg::*;

  fpst_e              st_q, st_d;
  logic               sign_q, sign_d, spec_q, spec_d, stk_q, stk_d;
  logic [31:0]        spec_bits_q, spec_bits_d;
  logic signed [10:0] e_q, e_d;
  logic [26:0]        sig_q, sig_d;
  logic [47:0]        prod_q, prod_d;
  logic [23:0]        a_q, a_d, b_q, b_d;
  logic [25:0]        r_q, r_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               done_q;
  logic [31:0]        bits_q, rnd_bits;

  // operand fields
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] sig_a, sig_b;
  logic signed [10:0] exp_a, exp_b;

  always_comb begin
    ea = req_i.a[30:23]; fa = req_i.a[22:0];
    eb = req_i.b[30:23]; fb = req_i.b[22:0];
    a_nan  = (ea == 8'hFF) && (fa != '0);
    b_nan  = (eb == 8'hFF) && (fb != '0);
    a_inf  = (ea == 8'hFF) && (fa == '0);
    b_inf  = (eb == 8'hFF) && (fb == '0);
    a_zero = (ea == 8'h00) && (fa == '0);
    b_zero = (eb == 8'h00) && (fb == '0);
    sig_a  = {ea != 8'h00, fa};
    sig_b  = {eb != 8'h00, fb};
    exp_a  = (ea == 8'h00) ? -11'sd126 : $signed({3'b000, ea}) - 11'sd127;
    exp_b  = (eb == 8'h00) ? -11'sd126 : $signed({3'b000, eb}) - 11'sd127;
  end

  // addition alignment
  logic        a_big;
  logic [7:0]  diff;
  logic [26:0] big27, small27, shifted, amask;
  logic [27:0] sum;
  logic        astk;
  logic signed [10:0] ebig;

  always_comb begin
    a_big   = (ea >= eb);
    diff    = a_big ? (ea - eb) : (eb - ea);
    big27   = a_big ? {sig_a, 3'b000} : {sig_b, 3'b000};
    small27 = a_big ? {sig_b, 3'b000} : {sig_a, 3'b000};
    ebig    = a_big ? exp_a : exp_b;
    amask   = (27'd1 << diff[4:0]) - 27'd1;
    if (diff >= 8'd27) begin
      shifted = '0;
      astk    = 1'b1;
    end else begin
      shifted = small27 >> diff[4:0];
      astk    = |(small27 & amask);
    end
    sum = {1'b0, big27} + {1'b0, shifted};
  end

  // rounding and packing
  logic signed [10:0] biased, shn;
  logic [26:0] m, smask;
  logic        st, up, ovf;
  logic [7:0]  bexp;
  logic [30:0] mag31;

  always_comb begin
    biased = e_q + 11'sd127;
    shn    = 11'sd1 - biased;
    ovf    = (biased >= 11'sd255);
    smask  = (27'd1 << shn[4:0]) - 27'd1;
    if (biased <= 11'sd0) begin
      bexp = 8'h00;
      if (shn >= 11'sd27) begin
        m  = '0;
        st = 1'b1;
      end else begin
        m  = sig_q >> shn[4:0];
        st = stk_q | (|(sig_q & smask));
      end
    end else begin
      bexp = biased[7:0];
      m    = sig_q;
      st   = stk_q;
    end
    up       = m[2] & (m[1] | m[0] | st | m[3]);
    mag31    = {bexp, m[25:3]} + 31'(up);
    rnd_bits = ovf ? {sign_q, F_INF[30:0]} : {sign_q, mag31};
  end

  // sequencer
  logic        ge;
  logic [25:0] rs;

  always_comb begin
    st_d = st_q; sign_d = sign_q; spec_d = spec_q; spec_bits_d = spec_bits_q;
    e_d = e_q; sig_d = sig_q; stk_d = stk_q; prod_d = prod_q;
    a_d = a_q; b_d = b_q; r_d = r_q; cnt_d = cnt_q;
    ge = (r_q >= {2'b00, b_q});
    rs = ge ? (r_q - {2'b00, b_q}) : r_q;

    case (st_q)
      FP_IDLE: begin
        if (req_i.start) begin
          spec_d = 1'b1;
          st_d   = FP_ROUND;
          sign_d = req_i.a[31] ^ req_i.b[31];
          case (req_i.op)
            FOP_MUL: begin
              if (a_nan || b_nan || (a_zero && b_inf) || (a_inf && b_zero)) begin
                spec_bits_d = F_QNAN;
              end else if (a_inf || b_inf) begin
                spec_bits_d = {sign_d, F_INF[30:0]};
              end else if (a_zero || b_zero) begin
                spec_bits_d = {sign_d, 31'd0};
              end else begin
                spec_d = 1'b0;
                prod_d = sig_a * sig_b;
                e_d    = exp_a + exp_b;
                st_d   = FP_MULN;
              end
            end
            FOP_ADD: begin
              sign_d = 1'b0;
              if (a_inf || b_inf) begin
                spec_bits_d = F_INF;
              end else if (b_zero) begin
                spec_bits_d = req_i.a;
              end else if (a_zero) begin
                spec_bits_d = req_i.b;
              end else begin
                spec_d = 1'b0;
                if (sum[27]) begin
                  sig_d = sum[27:1];
                  stk_d = astk | sum[0];
                  e_d   = ebig + 11'sd1;
                end else begin
                  sig_d = sum[26:0];
                  stk_d = astk;
                  e_d   = ebig;
                end
              end
            end
            FOP_DIV: begin
              if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                spec_bits_d = F_QNAN;
              end else if (a_inf || b_zero) begin
                spec_bits_d = {sign_d, F_INF[30:0]};
              end else if (b_inf || a_zero) begin
                spec_bits_d = {sign_d, 31'd0};
              end else begin
                spec_d = 1'b0;
                a_d    = sig_a;
                b_d    = sig_b;
                e_d    = exp_a - exp_b;
                st_d   = sig_a[23] ? FP_DIVP : FP_NORM;
              end
            end
            default: spec_bits_d = F_QNAN;
          endcase
        end
      end
      FP_MULN: begin
        if (prod_q[47]) begin
          sig_d = prod_q[47:21];
          stk_d = |prod_q[20:0];
          e_d   = e_q + 11'sd1;
        end else begin
          sig_d = prod_q[46:20];
          stk_d = |prod_q[19:0];
        end
        st_d = FP_ROUND;
      end
      FP_NORM: begin
        // subnormal dividend, one bit a cycle
        a_d = {a_q[22:0], 1'b0};
        e_d = e_q - 11'sd1;
        if (a_q[22]) st_d = FP_DIVP;
      end
      FP_DIVP: begin
        if (a_q < b_q) begin
          r_d = {1'b0, a_q, 1'b0};
          e_d = e_q - 11'sd1;
        end else begin
          r_d = {2'b00, a_q};
        end
        cnt_d = '0;
        sig_d = '0;
        st_d  = FP_DIV;
      end
      FP_DIV: begin
        // restoring division, one quotient bit a cycle
        sig_d = {sig_q[25:0], ge};
        r_d   = {rs[24:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd26) begin
          stk_d = (rs != '0);
          st_d  = FP_ROUND;
        end
      end
      FP_ROUND: st_d = FP_IDLE;
      default:  st_d = FP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= FP_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= (st_q == FP_ROUND);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sign_q      <= sign_d;
    spec_q      <= spec_d;
    spec_bits_q <= spec_bits_d;
    e_q         <= e_d;
    sig_q       <= sig_d;
    stk_q       <= stk_d;
    prod_q      <= prod_d;
    a_q         <= a_d;
    b_q         <= b_d;
    r_q         <= r_d;
    if (st_q == FP_ROUND) bits_q <= spec_q ? spec_bits_q : rnd_bits;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.bits = bits_q;

  `DTF_ASSERT(a_start_idle, req_i.start |-> st_q == FP_IDLE, "fpu started while busy")
  `DTF_ASSERT(a_done_pulse, done_q |=> !done_q, "fpu done longer than one cycle")
  `DTF_ASSERT_NEVER(a_div_count, st_q == FP_DIV && cnt_q > 5'd26, "divide ran too long")
  `DTF_ASSERT(a_nan_canon,
    done_q && bits_q[30:23] == 8'hFF && bits_q[22:0] != '0 |-> bits_q == F_QNAN,
    "non-canonical NaN")

endmodule
`default_nettype wire

@@ design/dtf_back.sv @@
// Back end: builds the mantissa digit by digit and scales it by powers of ten
// on the float unit, then holds the result beat. Depends on dtf_pkg.
`default_nettype none
module dtf_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  dtf_pkg::cmd_t      cmd_i,
  input  wire                empty_i,
  output logic               pop_o,
  output dtf_pkg::fpu_req_t  req_o,
  input  dtf_pkg::fpu_rsp_t  rsp_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [31:0]        value_bits_o,
  output logic [15:0]        chars_used_o,
  output logic [1:0]         status_o
);
  import dtf_pkg::*;

  bkst_e       st_q, st_d;
  logic [31:0] m_q, m_d, v_q, v_d, pw_q, pw_d;
  logic [7:0]  mag_q, mag_d;
  logic        exneg_q, exneg_d;
  logic [15:0] chars_q, chars_d;
  logic [1:0]  stat_q, stat_d;
  logic [3:0]  digit_q, digit_d;
  logic        ov_q, load;
  logic [31:0] ob_q;
  logic [15:0] oc_q;
  logic [1:0]  os_q;
  fpu_req_t    req;

  // sequencer
  always_comb begin
    st_d = st_q; m_d = m_q; v_d = v_q; pw_d = pw_q; mag_d = mag_q;
    exneg_d = exneg_q; chars_d = chars_q; stat_d = stat_q; digit_d = digit_q;
    pop_o = 1'b0; load = 1'b0;
    req = '{start: 1'b0, op: FOP_MUL, a: m_q, b: F_TEN};

    case (st_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_DIGIT: begin
              digit_d = cmd_i.digit;
              if (cmd_i.first) m_d = digit_to_float(cmd_i.digit);
              else st_d = BK_MUL10;
            end
            CMD_NODIGIT: begin
              v_d = '0; chars_d = '0; stat_d = ST_NODIGIT; st_d = BK_EMIT;
            end
            CMD_RANGE: begin
              v_d = F_INF; chars_d = '0; stat_d = ST_RANGE; st_d = BK_EMIT;
            end
            CMD_FINISH: begin
              v_d     = {cmd_i.neg, m_q[30:0]};
              pw_d    = F_TEN;
              mag_d   = cmd_i.mag;
              exneg_d = cmd_i.exneg;
              chars_d = cmd_i.chars;
              stat_d  = ST_OK;
              st_d    = BK_SCALE;
            end
            default: st_d = BK_IDLE;
          endcase
        end
      end
      BK_MUL10: begin
        req.start = 1'b1;
        st_d = BK_MUL10_W;
      end
      BK_MUL10_W: begin
        if (rsp_i.done) begin
          m_d  = rsp_i.bits;
          st_d = BK_ADD;
        end
      end
      BK_ADD: begin
        req = '{start: 1'b1, op: FOP_ADD, a: m_q, b: digit_to_float(digit_q)};
        st_d = BK_ADD_W;
      end
      BK_ADD_W: begin
        if (rsp_i.done) begin
          m_d  = rsp_i.bits;
          st_d = BK_IDLE;
        end
      end
      BK_SCALE: begin
        if (mag_q == '0) begin
          st_d = BK_EMIT;
        end else if (mag_q[0]) begin
          req = '{start: 1'b1, op: exneg_q ? FOP_DIV : FOP_MUL, a: v_q, b: pw_q};
          st_d = BK_SCALE_W;
        end else begin
          st_d = BK_SQ;
        end
      end
      BK_SCALE_W: begin
        if (rsp_i.done) begin
          v_d  = rsp_i.bits;
          st_d = BK_SQ;
        end
      end
      BK_SQ: begin
        // next power of ten, skipped once no exponent bits remain
        mag_d = {1'b0, mag_q[7:1]};
        if (mag_d == '0) begin
          st_d = BK_SCALE;
        end else begin
          req = '{start: 1'b1, op: FOP_MUL, a: pw_q, b: pw_q};
          st_d = BK_SQ_W;
        end
      end
      BK_SQ_W: begin
        if (rsp_i.done) begin
          pw_d = rsp_i.bits;
          st_d = BK_SCALE;
        end
      end
      BK_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          load = 1'b1;
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  assign req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      m_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      m_q  <= m_d;
      if (load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  // working and output beat registers
  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    pw_q    <= pw_d;
    mag_q   <= mag_d;
    exneg_q <= exneg_d;
    chars_q <= chars_d;
    stat_q  <= stat_d;
    digit_q <= digit_d;
    if (load) begin
      ob_q <= v_q;
      oc_q <= chars_q;
      os_q <= stat_q;
    end
  end

  assign out_valid_o  = ov_q;
  assign value_bits_o = ob_q;
  assign chars_used_o = oc_q;
  assign status_o     = os_q;

endmodule
`default_nettype wire

@@ design/decimal_text_to_float.sv @@
// Top level of the decimal text to binary32 converter.
// Depends on dtf_pkg, dtf_front, dtf_queue, dtf_fpu, dtf_back.
//
// One character is taken per beat; a beat with start_of_string_i set begins a
// new string. The front end parses each character and passes digit and
// end-of-string commands through a four entry queue, and stalls the input
// while the queue is full. Each digit after the first costs a rounded multiply
// by ten then a rounded add on the shared float unit in the back end. At the
// end of a string, scaling takes one multiply per exponent bit below the top
// one for the power of ten plus, per set bit, a multiply or a divide (one
// quotient bit a cycle, after a subnormal dividend is normalised one bit a
// cycle). The result beat waits in an output register while further characters
// are taken.
`default_nettype none
module decimal_text_to_float #(
  parameter int COUNT_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  char_code_i,
  input  wire         start_of_string_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] value_bits_o,
  output logic [15:0] chars_used_o,
  output logic [1:0]  status_o
);
  import dtf_pkg::*;

  cmd_t     push_cmd, pop_cmd;
  logic     push, full, pop, empty;
  fpu_req_t req;
  fpu_rsp_t rsp;

  dtf_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i, .rst_ni, .char_code_i, .start_of_string_i, .in_valid_i,
    .in_stall_o, .full_i(full), .push_o(push), .cmd_o(push_cmd)
  );

  dtf_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_cmd), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(pop_cmd)
  );

  dtf_fpu u_fpu (
    .clk_i, .rst_ni, .req_i(req), .rsp_o(rsp)
  );

  dtf_back u_back (
    .clk_i, .rst_ni, .cmd_i(pop_cmd), .empty_i(empty), .pop_o(pop),
    .req_o(req), .rsp_i(rsp), .out_valid_o, .out_stall_i,
    .value_bits_o, .chars_used_o, .status_o
  );

endmodule
`default_nettype wire
